// ----- rtl/core/cbnt_pkg.sv -----
`default_nettype none

package cbnt_pkg;

  // Configuration register width and reset values
  localparam int REG_W = 12;
  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Input command codes
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_END   = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/cbnt_in_if.sv -----
`default_nettype none

interface cbnt_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  contour_end;

  modport source (output valid, output cmd, output pos_x, output pos_y,
                  output contour_end, input ready);
  modport sink   (input valid, input cmd, input pos_x, input pos_y,
                  input contour_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cbnt_out_if.sv -----
`default_nettype none

interface cbnt_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-2:0] radius;
  logic                  found;

  modport source (output valid, output center_x, output center_y, output radius,
                  output found, input ready);
  modport sink   (input valid, input center_x, input center_y, input radius,
                  input found, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cbnt_cfg_if.sv -----
`default_nettype none

interface cbnt_cfg_if
  import cbnt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/contour_bbox_nearest_tracker.sv -----
// Contour tracker: contour points enter one per cycle; each contour is closed by a
// point with contour_end set, and each frame by an end command. The block keeps the
// bounding box of every closed contour, takes its centre (max minus half the span)
// and radius (half the larger span), and keeps the contour nearest in L1 distance
// to the previous frame's pick (first one wins a tie). Each end command yields one
// result: the chosen contour with found=1, or all zeros with found=0. Before the
// first frame ends the reference is the frame centre with radius max(width, height).
// Throughput is one item per cycle; each item passes through a four-stage pipeline
// (input, box, centre/radius, distance) that feeds the best-contour update, and
// an end command then loads the output register. The pipeline stalls only while an
// end command waits for the output register to be taken. Configuration writes are
// taken at any time (cfg ready is always high) and are meant for an idle block.
`default_nettype none

module contour_bbox_nearest_tracker
  import cbnt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire             clk,
  input  wire             rst_n,
  cbnt_in_if.sink         in_chan,
  cbnt_out_if.source      out_chan,
  cbnt_cfg_if.sink        cfg_chan
);

  localparam int CB = COORD_BITS;
  localparam int RB = COORD_BITS - 1;
  localparam int DW = COORD_BITS + 3;
  localparam int RW = (CB > REG_W) ? CB : REG_W;
  localparam int SW = ((RW + 2) > DW) ? (RW + 2) : DW;

  function automatic logic [RW-1:0] abs_diff(input logic [RW-1:0] a,
                                             input logic [RW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers
  logic [REG_W-1:0] frame_width_r, frame_width_nxt;
  logic [REG_W-1:0] frame_height_r, frame_height_nxt;

  // Stage 1: input register
  logic          s1_v_r, s1_v_nxt;
  logic          s1_cmd_r, s1_last_r;
  logic [CB-1:0] s1_x_r, s1_y_r;

  // Open contour box
  logic          open_r, open_nxt;
  logic [CB-1:0] box_min_x_r, box_max_x_r, box_min_y_r, box_max_y_r;
  logic [CB-1:0] box_min_x_nxt, box_max_x_nxt, box_min_y_nxt, box_max_y_nxt;

  // Stage 2: closed box or end marker
  logic          s2_v_r, s2_v_nxt, s2_end_r;
  logic [CB-1:0] s2_min_x_r, s2_max_x_r, s2_min_y_r, s2_max_y_r;

  // Stage 3: centre and radius
  logic          s3_v_r, s3_v_nxt, s3_end_r;
  logic [CB-1:0] s3_cx_r, s3_cy_r, s3_cx_nxt, s3_cy_nxt;
  logic [RB-1:0] s3_rad_r, s3_rad_nxt;

  // Stage 4: distance to reference
  logic          s4_v_r, s4_v_nxt, s4_end_r;
  logic [CB-1:0] s4_cx_r, s4_cy_r;
  logic [RB-1:0] s4_rad_r;
  logic [DW-1:0] s4_d_r, s4_d_nxt;

  // Best contour of the frame and reference
  logic          best_valid_r, best_valid_nxt;
  logic [DW-1:0] best_dist_r, best_dist_nxt;
  logic [CB-1:0] best_cx_r, best_cx_nxt, best_cy_r, best_cy_nxt;
  logic [RB-1:0] best_rad_r, best_rad_nxt;
  logic          ref_valid_r, ref_valid_nxt;
  logic [CB-1:0] ref_cx_r, ref_cx_nxt, ref_cy_r, ref_cy_nxt;
  logic [CB-1:0] ref_rad_r, ref_rad_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [CB-1:0] out_cx_r, out_cy_r;
  logic [RB-1:0] out_rad_r;
  logic          out_found_r;

  // Handshake and flow control
  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic in_fire, s1_move, s2_load, s3_load, s4_load;
  logic s4_take, end_take, out_free, cfg_fire;

  // Datapath temporaries
  logic          first_pt;
  logic [CB-1:0] span_x, span_y, span_max;
  logic [CB-1:0] rad_full;
  logic [CB-1:0] new_ref_rad;
  logic [RW-1:0] sel_cx, sel_cy, sel_rad;
  logic [SW-1:0] d_sum;
  logic          better;

  assign cfg_fire = cfg_chan.valid;
  assign out_free = !out_valid_r || out_chan.ready;
  assign s4_take  = s4_v_r && (!s4_end_r || out_free);
  assign end_take = s4_take && s4_end_r;
  assign s4_ready = !s4_v_r || s4_take;
  assign s3_ready = !s3_v_r || s4_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_fire  = in_chan.valid && s1_ready;
  assign s1_move  = s1_v_r && s2_ready;
  assign s2_load  = s1_move && ((s1_cmd_r == CMD_END) || s1_last_r);
  assign s3_load  = s2_v_r && s3_ready;
  assign s4_load  = s3_v_r && s4_ready;

  assign in_chan.ready     = s1_ready;
  assign cfg_chan.ready    = 1'b1;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.center_x = out_cx_r;
  assign out_chan.center_y = out_cy_r;
  assign out_chan.radius   = out_rad_r;
  assign out_chan.found    = out_found_r;

  always_comb begin
    // Configuration writes
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_fire) begin
      unique case (cfg_chan.index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_chan.data;
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_chan.data;
        default: ;
      endcase
    end

    // Valid bits of the pipeline
    s1_v_nxt = in_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_v_r);
    s2_v_nxt = s2_load ? 1'b1 : (s3_ready ? 1'b0 : s2_v_r);
    s3_v_nxt = s3_load ? 1'b1 : (s4_ready ? 1'b0 : s3_v_r);
    s4_v_nxt = s4_load ? 1'b1 : (s4_take ? 1'b0 : s4_v_r);

    // Grow the box of the open contour, or start it on the first point
    first_pt      = !open_r;
    box_min_x_nxt = box_min_x_r;
    box_max_x_nxt = box_max_x_r;
    box_min_y_nxt = box_min_y_r;
    box_max_y_nxt = box_max_y_r;
    open_nxt      = open_r;
    if (s1_move) begin
      if (s1_cmd_r == CMD_POINT) begin
        box_min_x_nxt = (first_pt || s1_x_r < box_min_x_r) ? s1_x_r : box_min_x_r;
        box_max_x_nxt = (first_pt || s1_x_r > box_max_x_r) ? s1_x_r : box_max_x_r;
        box_min_y_nxt = (first_pt || s1_y_r < box_min_y_r) ? s1_y_r : box_min_y_r;
        box_max_y_nxt = (first_pt || s1_y_r > box_max_y_r) ? s1_y_r : box_max_y_r;
        open_nxt      = !s1_last_r;
      end else begin
        open_nxt = 1'b0;
      end
    end

    // Centre and radius of a closed box
    span_x     = s2_max_x_r - s2_min_x_r;
    span_y     = s2_max_y_r - s2_min_y_r;
    s3_cx_nxt  = s2_max_x_r - (span_x >> 1);
    s3_cy_nxt  = s2_max_y_r - (span_y >> 1);
    span_max   = (span_x > span_y) ? span_x : span_y;
    rad_full   = span_max >> 1;
    s3_rad_nxt = rad_full[RB-1:0];

    // Reference for the next frame, forwarded when an end command retires now
    new_ref_rad = (best_rad_r == '0) ? CB'(1) : CB'(best_rad_r);
    if (end_take) begin
      sel_cx  = RW'(best_cx_r);
      sel_cy  = RW'(best_cy_r);
      sel_rad = RW'(new_ref_rad);
    end else if (ref_valid_r) begin
      sel_cx  = RW'(ref_cx_r);
      sel_cy  = RW'(ref_cy_r);
      sel_rad = RW'(ref_rad_r);
    end else begin
      sel_cx  = RW'(frame_width_r >> 1);
      sel_cy  = RW'(frame_height_r >> 1);
      sel_rad = RW'((frame_width_r > frame_height_r) ? frame_width_r : frame_height_r);
    end

    // L1 distance of centre and radius to the reference
    d_sum = SW'(abs_diff(sel_cx, RW'(s3_cx_r))) + SW'(abs_diff(sel_cy, RW'(s3_cy_r)))
          + SW'(abs_diff(sel_rad, RW'(s3_rad_r)));
    s4_d_nxt = d_sum[DW-1:0];

    // Keep the nearest contour; an end command retires it and clears the frame
    better         = !best_valid_r || (s4_d_r < best_dist_r);
    best_valid_nxt = best_valid_r;
    best_dist_nxt  = best_dist_r;
    best_cx_nxt    = best_cx_r;
    best_cy_nxt    = best_cy_r;
    best_rad_nxt   = best_rad_r;
    ref_valid_nxt  = ref_valid_r;
    ref_cx_nxt     = ref_cx_r;
    ref_cy_nxt     = ref_cy_r;
    ref_rad_nxt    = ref_rad_r;
    if (end_take) begin
      ref_valid_nxt  = 1'b1;
      ref_cx_nxt     = best_cx_r;
      ref_cy_nxt     = best_cy_r;
      ref_rad_nxt    = new_ref_rad;
      best_valid_nxt = 1'b0;
      best_dist_nxt  = '0;
      best_cx_nxt    = '0;
      best_cy_nxt    = '0;
      best_rad_nxt   = '0;
    end else if (s4_take && better) begin
      best_valid_nxt = 1'b1;
      best_dist_nxt  = s4_d_r;
      best_cx_nxt    = s4_cx_r;
      best_cy_nxt    = s4_cy_r;
      best_rad_nxt   = s4_rad_r;
    end

    // Hold the result until its transfer
    out_valid_nxt = end_take ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      s4_v_r         <= 1'b0;
      open_r         <= 1'b0;
      box_min_x_r    <= '0;
      box_max_x_r    <= '0;
      box_min_y_r    <= '0;
      box_max_y_r    <= '0;
      best_valid_r   <= 1'b0;
      best_dist_r    <= '0;
      best_cx_r      <= '0;
      best_cy_r      <= '0;
      best_rad_r     <= '0;
      ref_valid_r    <= 1'b0;
      ref_cx_r       <= '0;
      ref_cy_r       <= '0;
      ref_rad_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      s1_v_r         <= s1_v_nxt;
      s2_v_r         <= s2_v_nxt;
      s3_v_r         <= s3_v_nxt;
      s4_v_r         <= s4_v_nxt;
      open_r         <= open_nxt;
      box_min_x_r    <= box_min_x_nxt;
      box_max_x_r    <= box_max_x_nxt;
      box_min_y_r    <= box_min_y_nxt;
      box_max_y_r    <= box_max_y_nxt;
      best_valid_r   <= best_valid_nxt;
      best_dist_r    <= best_dist_nxt;
      best_cx_r      <= best_cx_nxt;
      best_cy_r      <= best_cy_nxt;
      best_rad_r     <= best_rad_nxt;
      ref_valid_r    <= ref_valid_nxt;
      ref_cx_r       <= ref_cx_nxt;
      ref_cy_r       <= ref_cy_nxt;
      ref_rad_r      <= ref_rad_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_chan.cmd;
      s1_x_r    <= in_chan.pos_x;
      s1_y_r    <= in_chan.pos_y;
      s1_last_r <= in_chan.contour_end;
    end
    if (s2_load) begin
      s2_end_r   <= (s1_cmd_r == CMD_END);
      s2_min_x_r <= box_min_x_nxt;
      s2_max_x_r <= box_max_x_nxt;
      s2_min_y_r <= box_min_y_nxt;
      s2_max_y_r <= box_max_y_nxt;
    end
    if (s3_load) begin
      s3_end_r <= s2_end_r;
      s3_cx_r  <= s3_cx_nxt;
      s3_cy_r  <= s3_cy_nxt;
      s3_rad_r <= s3_rad_nxt;
    end
    if (s4_load) begin
      s4_end_r <= s3_end_r;
      s4_cx_r  <= s3_cx_r;
      s4_cy_r  <= s3_cy_r;
      s4_rad_r <= s3_rad_r;
      s4_d_r   <= s4_d_nxt;
    end
    if (end_take) begin
      out_cx_r    <= best_cx_r;
      out_cy_r    <= best_cy_r;
      out_rad_r   <= best_rad_r;
      out_found_r <= best_valid_r;
    end
  end

  // A frame without contours reports all zeros
  a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_cx_r == '0 && out_cy_r == '0 && out_rad_r == '0))
    else $error("empty frame result is not zero");

  // Retiring an end command clears the frame's best contour
  a_end_clears_best: assert property (@(posedge clk) disable iff (!rst_n)
    end_take |=> !best_valid_r)
    else $error("best contour not cleared at end of frame");

  // Once set, the reference stays valid and its radius is never zero
  a_ref_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ref_valid_r |=> (ref_valid_r && ref_rad_r != '0))
    else $error("reference lost or radius zero");

  // The open box is well ordered
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (box_min_x_r <= box_max_x_r && box_min_y_r <= box_max_y_r))
    else $error("open contour box out of order");

  // The best contour does not change while an end command waits for the output
  a_best_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_end_r && !out_free) |=> $stable(best_cx_r) && $stable(best_valid_r))
    else $error("best contour changed during output stall");

endmodule

`default_nettype wire

// ----- test/contour_bbox_nearest_tracker_tb.sv -----
`default_nettype none

module contour_bbox_nearest_tracker_tb
  import cbnt_pkg::*;
;

  localparam int CB = 12;

  typedef struct packed {
    logic [CB-1:0] center_x;
    logic [CB-1:0] center_y;
    logic [CB-2:0] radius;
    logic          found;
  } track_t;

  logic clk = 1'b0;
  logic rst_n;

  cbnt_in_if  #(.COORD_BITS(CB)) in_chan ();
  cbnt_out_if #(.COORD_BITS(CB)) out_chan ();
  cbnt_cfg_if                    cfg_chan ();

  contour_bbox_nearest_tracker #(.COORD_BITS(CB)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tracker state as the testbench sees it
  logic [REG_W-1:0] img_w, img_h;
  logic [CB-1:0]    box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  logic             box_open;
  logic [CB+2:0]    cand_dist;
  logic [CB-1:0]    cand_cx, cand_cy;
  logic [CB-2:0]    cand_r;
  logic             cand_valid;
  logic [CB-1:0]    anchor_cx, anchor_cy, anchor_r;
  logic             anchor_valid;

  track_t pending_tracks[$];

  int error_count    = 0;
  int items_sent     = 0;
  int points_taken   = 0;
  int frames_taken   = 0;
  int tracks_checked = 0;
  int hold_request   = 0;
  bit gaps_on        = 1'b1;

  function automatic logic [CB-1:0] abs_gap(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Score a closed box against the reference and keep it if nearer
  function automatic void close_box();
    logic [CB-1:0] span_x, span_y, wide, cx, cy, rx, ry, rr;
    logic [CB-2:0] r;
    logic [CB+2:0] d;
    span_x = box_hi_x - box_lo_x;
    span_y = box_hi_y - box_lo_y;
    cx     = box_hi_x - (span_x >> 1);
    cy     = box_hi_y - (span_y >> 1);
    wide   = (span_x > span_y) ? span_x : span_y;
    r      = wide[CB-1:1];
    if (anchor_valid) begin
      rx = anchor_cx;
      ry = anchor_cy;
      rr = anchor_r;
    end else begin
      rx = img_w >> 1;
      ry = img_h >> 1;
      rr = (img_w > img_h) ? img_w : img_h;
    end
    d = (CB+3)'(abs_gap(rx, cx)) + (CB+3)'(abs_gap(ry, cy)) + (CB+3)'(abs_gap(rr, {1'b0, r}));
    if (!cand_valid || d < cand_dist) begin
      cand_valid = 1'b1;
      cand_dist  = d;
      cand_cx    = cx;
      cand_cy    = cy;
      cand_r     = r;
    end
  endfunction

  // Grow the open box by one point, close it on the last point
  function automatic void fold_point(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                     input logic last);
    if (!box_open) begin
      box_lo_x = x; box_hi_x = x;
      box_lo_y = y; box_hi_y = y;
    end else begin
      if (x < box_lo_x) box_lo_x = x;
      if (x > box_hi_x) box_hi_x = x;
      if (y < box_lo_y) box_lo_y = y;
      if (y > box_hi_y) box_hi_y = y;
    end
    if (last) begin
      close_box();
      box_open = 1'b0;
    end else begin
      box_open = 1'b1;
    end
  endfunction

  // Report the frame's pick, move the reference, drop any open contour
  function automatic void finish_frame();
    track_t t;
    if (cand_valid) begin
      t = '{center_x: cand_cx, center_y: cand_cy, radius: cand_r, found: 1'b1};
      anchor_cx = cand_cx;
      anchor_cy = cand_cy;
      anchor_r  = (cand_r == '0) ? CB'(1) : CB'(cand_r);
    end else begin
      t = '0;
      anchor_cx = '0;
      anchor_cy = '0;
      anchor_r  = CB'(1);
    end
    pending_tracks.push_back(t);
    anchor_valid = 1'b1;
    box_open     = 1'b0;
    cand_valid   = 1'b0;
    cand_dist    = '0;
    cand_cx      = '0;
    cand_cy      = '0;
    cand_r       = '0;
  endfunction

  // Follow every transfer on the input and configuration channels
  always @(posedge clk) begin
    if (!rst_n) begin
      img_w = FRAME_WIDTH_RST;  img_h = FRAME_HEIGHT_RST;
      box_lo_x = '0; box_hi_x = '0; box_lo_y = '0; box_hi_y = '0;
      box_open = 1'b0;
      cand_dist = '0; cand_cx = '0; cand_cy = '0; cand_r = '0; cand_valid = 1'b0;
      anchor_cx = '0; anchor_cy = '0; anchor_r = '0; anchor_valid = 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == CFG_FRAME_WIDTH)       img_w = cfg_chan.data;
        else if (cfg_chan.index == CFG_FRAME_HEIGHT) img_h = cfg_chan.data;
      end
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.cmd == CMD_POINT) begin
          fold_point(in_chan.pos_x, in_chan.pos_y, in_chan.contour_end);
          points_taken++;
        end else begin
          finish_frame();
          frames_taken++;
        end
      end
    end
  end

  // Compare each result transfer with the oldest expected track
  always @(posedge clk) begin
    track_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_tracks.size() == 0) begin
        $error("unexpected result: center_x %0d center_y %0d radius %0d found %0d",
               out_chan.center_x, out_chan.center_y, out_chan.radius, out_chan.found);
        error_count++;
      end else begin
        want = pending_tracks.pop_front();
        tracks_checked++;
        if (out_chan.center_x !== want.center_x) begin
          $error("center_x: expected %0d, got %0d", want.center_x, out_chan.center_x);
          error_count++;
        end
        if (out_chan.center_y !== want.center_y) begin
          $error("center_y: expected %0d, got %0d", want.center_y, out_chan.center_y);
          error_count++;
        end
        if (out_chan.radius !== want.radius) begin
          $error("radius: expected %0d, got %0d", want.radius, out_chan.radius);
          error_count++;
        end
        if (out_chan.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_chan.found);
          error_count++;
        end
      end
    end
  end

  // Result side: random gaps, plus a long hold-off when a test asks for one
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (gaps_on && $urandom_range(99) < 17) begin
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one item, with random gaps ahead of it, and hold until transferred
  task automatic send_item(input logic c, input logic [CB-1:0] x, input logic [CB-1:0] y,
                           input logic last);
    if (gaps_on) begin
      while ($urandom_range(99) < 17) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= c;
    in_chan.pos_x       <= x;
    in_chan.pos_y       <= y;
    in_chan.contour_end <= last;
    items_sent++;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_point(input logic [CB-1:0] x, input logic [CB-1:0] y, input logic last);
    send_item(CMD_POINT, x, y, last);
  endtask

  // End of frame; the point fields carry noise
  task automatic send_end();
    send_item(CMD_END, CB'($urandom), CB'($urandom), 1'($urandom));
  endtask

  // Stop offering and wait until every expected track has come out
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= CFG_FRAME_WIDTH;
    cfg_chan.data  <= w;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.index <= CFG_FRAME_HEIGHT;
    cfg_chan.data  <= h;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  // Corners, ties, empty frames, discarded contours, zero radius
  task automatic test_directed();
    write_frame_size(12'd4095, 12'd1);
    // first frame scores against the configured frame size
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd4095, 12'd4095, 1'b1);
    send_point(12'd0, 12'd4095, 1'b0);
    send_point(12'd4095, 12'd0, 1'b0);
    send_point(12'd2048, 12'd2048, 1'b1);
    send_point(12'd4095, 12'd0, 1'b0);
    send_point(12'd0, 12'd4095, 1'b1);
    send_point(12'd1000, 12'd10, 1'b0);
    send_point(12'd3094, 12'd10, 1'b1);
    send_end();
    // empty frame, then a contour left open at end of frame
    send_end();
    send_point(12'd5, 12'd5, 1'b0);
    send_point(12'd6, 12'd6, 1'b0);
    send_item(CMD_END, 12'd4095, 12'd4095, 1'b1);
    // single point contour, radius floors at one for the next frame
    send_point(12'd7, 12'd9, 1'b1);
    send_end();
    send_point(12'd8, 12'd9, 1'b1);
    send_point(12'd7, 12'd9, 1'b1);
    send_point(12'd300, 12'd200, 1'b0);
    send_point(12'd100, 12'd400, 1'b0);
    send_point(12'd200, 12'd100, 1'b1);
    send_end();
    settle();
  endtask

  // Sweep the frame size registers between short frames
  task automatic test_config_sweep();
    write_frame_size(12'd1, 12'd4095);
    send_point(12'd1, 12'd4094, 1'b1);
    send_end();
    settle();
    write_frame_size(12'd0, 12'd0);
    send_point(12'd0, 12'd1, 1'b0);
    send_point(12'd2, 12'd3, 1'b1);
    send_end();
    settle();
    write_frame_size(12'd2730, 12'd1365);
    send_point(12'd2730, 12'd1365, 1'b1);
    send_end();
    settle();
    write_frame_size(FRAME_WIDTH_RST, FRAME_HEIGHT_RST);
  endtask

  // Hold the result side off while frames keep coming, then drain
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 120;
    for (int k = 0; k < 14; k++) begin
      send_point(CB'($urandom), CB'($urandom), 1'b1);
      send_end();
    end
    settle();
    gaps_on = 1'b1;
  endtask

  function automatic logic [CB-1:0] pick_coord(input logic [CB-1:0] base, input int mode);
    int v;
    if (mode < 4) begin
      v = int'(base) + $urandom_range(0, 64) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return CB'(v);
    end
    if (mode < 8) return CB'($urandom);
    return $urandom_range(1) ? CB'(4095 - $urandom_range(0, 3)) : CB'($urandom_range(0, 3));
  endfunction

  // Random frames: well-formed contours near the reference, anywhere or at the corners,
  // some repeats for ties, some abandoned contours
  task automatic test_random();
    int start, n_contours, n_pts, mode;
    logic [CB-1:0] pts_x[8], pts_y[8];
    start = items_sent;
    n_pts = 0;
    while (items_sent - start < 450) begin
      gaps_on = !((items_sent - start >= 150) && (items_sent - start < 300));
      n_contours = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 5);
      for (int k = 0; k < n_contours; k++) begin
        if (n_pts == 0 || $urandom_range(99) >= 15) begin
          n_pts = ($urandom_range(99) < 25) ? 1 : $urandom_range(2, 8);
          mode  = $urandom_range(0, 9);
          for (int j = 0; j < n_pts; j++) begin
            pts_x[j] = pick_coord(anchor_cx, mode);
            pts_y[j] = pick_coord(anchor_cy, mode);
          end
        end
        for (int j = 0; j < n_pts; j++) send_point(pts_x[j], pts_y[j], j == n_pts - 1);
      end
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 3)) send_point(CB'($urandom), CB'($urandom), 1'b0);
      end
      send_end();
      if ($urandom_range(99) < 5) settle();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.cmd         = CMD_POINT;
    in_chan.pos_x       = '0;
    in_chan.pos_y       = '0;
    in_chan.contour_end = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = CFG_FRAME_WIDTH;
    cfg_chan.data       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();

    // drain and let the pipeline run out
    settle();
    $display("Covered %0d points and %0d frame ends; %0d tracks checked, %0d mismatches.",
             points_taken, frames_taken, tracks_checked, error_count);
    if (error_count == 0 && pending_tracks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- contour_bbox_nearest_tracker.f -----
rtl/core/cbnt_pkg.sv
rtl/core/cbnt_in_if.sv
rtl/core/cbnt_out_if.sv
rtl/core/cbnt_cfg_if.sv
rtl/core/contour_bbox_nearest_tracker.sv
test/contour_bbox_nearest_tracker_tb.sv
